// File: hdl/u2l_pkg.sv
// Shared types, constants and helpers for the UTF-8 to Latin-1 stream decoder.
// No dependencies.
package u2l_pkg;

  localparam int CNT_W = 9;
  localparam logic [CNT_W-1:0] TEXT_LIMIT = 9'd256;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [31:0] CP_MAX    = 32'h0010_FFFF;
  localparam logic [31:0] LATIN_MAX = 32'd255;
  localparam logic [7:0]  SPACE_CH  = 8'h20;

  // Results caused by one input byte: up to two characters and an end item.
  typedef struct packed {
    logic             c0_v;
    logic [7:0]       c0;
    logic             c1_v;
    logic [7:0]       c1;
    logic             end_v;
    logic [CNT_W-1:0] total;
  } bundle_t;

  function automatic logic cp_emits(input logic [31:0] cp);
    return cp <= CP_MAX;
  endfunction

  function automatic logic [7:0] cp_char(input logic [31:0] cp);
    return (cp <= LATIN_MAX) ? cp[7:0] : SPACE_CH;
  endfunction

endpackage

// File: hdl/u2l_front.sv
// Front end: accepts bytes, tracks the code point and per-text state,
// builds one result bundle per byte. Depends on u2l_pkg.
module u2l_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [u2l_pkg::CNT_W-1:0] cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_text_byte,
  input  logic                   in_is_last,
  input  logic                   q_full,
  output logic                   q_push,
  output u2l_pkg::bundle_t       q_data
);
  import u2l_pkg::*;

  logic [CNT_W-1:0] max_len_r;
  logic [31:0]      acc_r, acc_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             lim_r, lim_nxt;

  logic [31:0]      acc_t;
  logic             pend_t, lim_t, is_cont, ends;
  logic [CNT_W-1:0] cnt_t, limit;
  bundle_t          bnd;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign limit    = (max_len_r > TEXT_LIMIT) ? TEXT_LIMIT : max_len_r;
  assign is_cont  = in_text_byte inside {[8'h80:8'hBF]};
  assign ends     = (in_text_byte == 8'h00) || in_is_last;

  always_comb begin
    acc_t  = acc_r;
    pend_t = pend_r;
    cnt_t  = cnt_r;
    lim_t  = lim_r;
    bnd    = '0;
    if (in_text_byte != 8'h00 && !lim_r) begin
      if (is_cont && pend_r) begin
        acc_t = {acc_r[25:0], in_text_byte[5:0]};
      end else begin
        if (pend_r && cp_emits(acc_r)) begin
          bnd.c0_v = 1'b1;
          bnd.c0   = cp_char(acc_r);
          cnt_t    = cnt_r + 1'b1;
        end
        pend_t = 1'b0;
        if (cnt_t >= limit) begin
          lim_t = 1'b1;
        end else begin
          pend_t = 1'b1;
          if (in_text_byte <= 8'h7F)      acc_t = {24'd0, in_text_byte};
          else if (is_cont)               acc_t = {acc_r[25:0], in_text_byte[5:0]};
          else if (in_text_byte <= 8'hDF) acc_t = {27'd0, in_text_byte[4:0]};
          else if (in_text_byte <= 8'hEF) acc_t = {28'd0, in_text_byte[3:0]};
          else                            acc_t = {29'd0, in_text_byte[2:0]};
        end
      end
    end
    if (ends) begin
      if (!lim_t && pend_t && cp_emits(acc_t)) begin
        bnd.c1_v = 1'b1;
        bnd.c1   = cp_char(acc_t);
        cnt_t    = cnt_t + 1'b1;
      end
      bnd.end_v = 1'b1;
      bnd.total = cnt_t;
    end
  end

  always_comb begin
    if (ends) begin
      acc_nxt  = '0;
      pend_nxt = 1'b0;
      cnt_nxt  = '0;
      lim_nxt  = 1'b0;
    end else begin
      acc_nxt  = acc_t;
      pend_nxt = pend_t;
      cnt_nxt  = cnt_t;
      lim_nxt  = lim_t;
    end
  end

  assign q_push = accept && (bnd.c0_v || bnd.c1_v || bnd.end_v);
  assign q_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= TEXT_LIMIT;
      acc_r     <= '0;
      pend_r    <= 1'b0;
      cnt_r     <= '0;
      lim_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) max_len_r <= cfg_wr_data;
      if (accept) begin
        acc_r  <= acc_nxt;
        pend_r <= pend_nxt;
        cnt_r  <= cnt_nxt;
        lim_r  <= lim_nxt;
      end
    end
  end

endmodule

// File: hdl/u2l_queue.sv
// Short bundle FIFO between front and back end.
// Depends on u2l_pkg.
module u2l_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u2l_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output u2l_pkg::bundle_t head_data
);
  import u2l_pkg::*;

  bundle_t           slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_data = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: hdl/u2l_back.sv
// Back end: unpacks each bundle into result transactions, one per cycle
// while out_ready is high. Depends on u2l_pkg.
module u2l_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_not_empty,
  input  u2l_pkg::bundle_t          q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_latin1_char,
  output logic                      out_end_of_text,
  output logic [u2l_pkg::CNT_W-1:0] out_char_total
);
  import u2l_pkg::*;

  bundle_t    cur_r;
  logic [2:0] mask_r, mask_nxt, mask_left;
  logic       take;

  assign out_valid = (mask_r != 3'b000);
  // drop lowest pending entry once taken
  assign mask_left = mask_r & (mask_r - 3'd1);
  assign take      = !out_valid || (out_ready && (mask_left == 3'b000));
  assign q_pop     = take && q_not_empty;

  always_comb begin
    out_latin1_char = 8'h00;
    out_end_of_text = 1'b0;
    out_char_total  = '0;
    if (mask_r[0]) begin
      out_latin1_char = cur_r.c0;
    end else if (mask_r[1]) begin
      out_latin1_char = cur_r.c1;
    end else if (mask_r[2]) begin
      out_end_of_text = 1'b1;
      out_char_total  = cur_r.total;
    end
  end

  always_comb begin
    mask_nxt = mask_r;
    if (q_pop)
      mask_nxt = {q_head.end_v, q_head.c1_v, q_head.c0_v};
    else if (out_valid && out_ready)
      mask_nxt = mask_left;
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mask_r <= 3'b000;
    else        mask_r <= mask_nxt;
  end

endmodule

// File: hdl/utf8_to_latin1_stream.sv
// Top level of the UTF-8 to Latin-1 stream decoder.
// Depends on u2l_pkg, u2l_front, u2l_queue and u2l_back.
//
// Takes one UTF-8 byte per cycle and returns Latin-1 characters: code points
// up to 0xFF as is, up to 0x10FFFF as a space, larger ones dropped. A zero
// byte or in_is_last closes the text, after which an end transaction carries
// the character count in out_char_total. At most min(max_length, 256)
// characters are produced per text; later bytes up to the end are ignored.
// Each byte is taken when the four-entry queue has room; a byte can cause up
// to three results, and the output side delivers one result per cycle while
// out_ready is high, so sustained input rate is one byte per cycle as long as
// results average no more than one per byte and out_ready stays high. A byte's
// results are written to the queue and then loaded into the back end before
// they reach the output. max_length is written via cfg_wr_en/cfg_wr_data and
// should only be changed while no text is in flight.
module utf8_to_latin1_stream (
  input  logic                      clk,
  input  logic                      rst_n,
  // configuration
  input  logic                      cfg_wr_en,
  input  logic [u2l_pkg::CNT_W-1:0] cfg_wr_data,
  // byte input transactions
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_text_byte,
  input  logic                      in_is_last,
  // result transactions
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_latin1_char,
  output logic                      out_end_of_text,
  output logic [u2l_pkg::CNT_W-1:0] out_char_total
);
  import u2l_pkg::*;

  bundle_t push_data, head_data;
  logic    push, full, pop, not_empty;

  // front: decode and per-text bookkeeping
  u2l_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .in_is_last   (in_is_last),
    .q_full       (full),
    .q_push       (push),
    .q_data       (push_data)
  );

  // decouples byte intake from result delivery
  u2l_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head_data (head_data)
  );

  // back: serialise bundles onto the output channel
  u2l_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (not_empty),
    .q_head          (head_data),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_latin1_char (out_latin1_char),
    .out_end_of_text (out_end_of_text),
    .out_char_total  (out_char_total)
  );

endmodule
